// ===== sv/lbts_pkg.sv =====
`timescale 1ns / 1ps

package lbts_pkg;

   // Transfer geometry.
   localparam int BLOCK_BYTES = 8192;
   localparam int CHUNK_BYTES = 131072;

   // Field and counter widths.
   localparam int TOTAL_W  = 26;
   localparam int OFFSET_W = 25;
   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int SUM_W    = 16;
   localparam int CHUNK_W  = $clog2(CHUNK_BYTES + 1);
   localparam int BLOCK_W  = $clog2(BLOCK_BYTES + 1);
   localparam int ADDR_W   = 2;

   // Register map.
   localparam logic [ADDR_W-1:0] CSR_TOTAL_BYTES_ADDR = 2'd0;

   // Action codes.
   localparam logic ACT_RESTART  = 1'b0;
   localparam logic ACT_EXCHANGE = 1'b1;

   // Link words sent by this side and replies expected from the partner.
   localparam logic [WORD_W-1:0] W_SYNC1 = 32'hAAAA5555;
   localparam logic [WORD_W-1:0] R_SYNC1 = 32'h5555AAAA;
   localparam logic [WORD_W-1:0] W_SYNC2 = 32'h11112222;
   localparam logic [WORD_W-1:0] R_SYNC2 = 32'h22221111;
   localparam logic [WORD_W-1:0] W_CHUNK = 32'h12345678;
   localparam logic [WORD_W-1:0] W_READY = 32'hCAFEBABE;
   localparam logic [WORD_W-1:0] R_READY = 32'hDEADBEEF;
   localparam logic [WORD_W-1:0] R_FLASH = 32'hACEDACED;
   localparam logic [WORD_W-1:0] W_DONE  = 32'hBBBBBBBB;

   // Protocol phase of the word last sent.
   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CHUNK = 3'd2,
      PH_READY = 3'd3,
      PH_BYTES = 3'd4,
      PH_CSUM  = 3'd5,
      PH_FLASH = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

endpackage

// ===== sv/link_block_transfer_sender.sv =====
`timescale 1ns / 1ps

// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle unless a result waits on rsp_ready; the whole
// protocol step is one pass of logic between state and result registers.
// Reset (synchronous, active high): phase goes to done, all progress, both
// block counters and total_bytes clear, and the result register empties.
module link_block_transfer_sender (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [lbts_pkg::WORD_W-1:0]   req_rx_word,
   input  logic [lbts_pkg::BYTE_W-1:0]   req_data_byte,
   // Result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lbts_pkg::WORD_W-1:0]   rsp_tx_word,
   output logic [lbts_pkg::OFFSET_W-1:0] rsp_byte_offset,
   output logic [2:0]                    rsp_phase,
   output logic [31:0]                   rsp_blocks_ok,
   output logic [31:0]                   rsp_blocks_failed,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lbts_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import lbts_pkg::*;

   localparam logic [TOTAL_W-1:0] CHUNK_LIMIT = TOTAL_W'(CHUNK_BYTES);
   localparam logic [CHUNK_W-1:0] BLOCK_LIMIT = CHUNK_W'(BLOCK_BYTES);

   // Registers
   logic [TOTAL_W-1:0]  total_bytes_ff;
   phase_type           phase_ff, phase_in;
   logic [TOTAL_W-1:0]  sent_total_ff, sent_total_in;
   logic [CHUNK_W-1:0]  chunk_length_ff, chunk_length_in;
   logic [CHUNK_W-1:0]  chunk_sent_ff, chunk_sent_in;
   logic [BLOCK_W-1:0]  block_length_ff, block_length_in;
   logic [BLOCK_W-1:0]  block_sent_ff, block_sent_in;
   logic [SUM_W-1:0]    running_sum_ff, running_sum_in;
   logic [31:0]         ok_count_ff, ok_count_in;
   logic [31:0]         fail_count_ff, fail_count_in;

   logic                out_valid_ff;
   logic [WORD_W-1:0]   out_tx_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   phase_type           out_phase_ff;
   logic [31:0]         out_ok_ff;
   logic [31:0]         out_fail_ff;

   // Step logic
   logic                accept;
   logic                has_result;
   logic [WORD_W-1:0]   tx_word;
   logic [TOTAL_W-1:0]  data_left;
   logic [CHUNK_W-1:0]  chunk_left;
   logic [CHUNK_W-1:0]  block_len_next;
   logic                csr_write;

   // An item is taken whenever the result register is empty or draining.
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Bytes still to send overall and within the current chunk.
   assign data_left  = (total_bytes_ff > sent_total_ff) ? (total_bytes_ff - sent_total_ff)
                                                        : '0;
   assign chunk_left = chunk_length_ff - chunk_sent_ff;
   assign block_len_next = (chunk_left > BLOCK_LIMIT) ? BLOCK_LIMIT : chunk_left;

   // Next state and the word to send for one exchange.
   always_comb begin
      phase_in        = phase_ff;
      sent_total_in   = sent_total_ff;
      chunk_length_in = chunk_length_ff;
      chunk_sent_in   = chunk_sent_ff;
      block_length_in = block_length_ff;
      block_sent_in   = block_sent_ff;
      running_sum_in  = running_sum_ff;
      ok_count_in     = ok_count_ff;
      fail_count_in   = fail_count_ff;
      has_result      = 1'b1;
      tx_word         = W_READY;

      if (req_action == ACT_RESTART) begin
         sent_total_in   = '0;
         chunk_length_in = '0;
         chunk_sent_in   = '0;
         block_length_in = '0;
         block_sent_in   = '0;
         running_sum_in  = '0;
         ok_count_in     = '0;
         fail_count_in   = '0;
         phase_in        = PH_SYNC1;
         tx_word         = W_SYNC1;
      end else begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (req_rx_word == R_SYNC1) begin
                  phase_in = PH_SYNC2;
                  tx_word  = W_SYNC2;
               end else begin
                  tx_word = W_SYNC1;
               end
            end
            PH_SYNC2: begin
               if (req_rx_word != R_SYNC2) begin
                  phase_in = PH_SYNC1;
                  tx_word  = W_SYNC1;
               end else if (sent_total_ff < total_bytes_ff) begin
                  phase_in = PH_CHUNK;
                  tx_word  = W_CHUNK;
               end else begin
                  phase_in = PH_DONE;
                  tx_word  = W_DONE;
               end
            end
            PH_CHUNK: begin
               chunk_length_in = (data_left > CHUNK_LIMIT) ? CHUNK_W'(CHUNK_BYTES)
                                                           : data_left[CHUNK_W-1:0];
               chunk_sent_in   = '0;
               phase_in        = (data_left != '0) ? PH_READY : PH_FLASH;
               tx_word         = W_READY;
            end
            PH_READY: begin
               // A ready reply opens a block and sends its first byte.
               if (req_rx_word == R_READY) begin
                  block_length_in = block_len_next[BLOCK_W-1:0];
                  block_sent_in   = BLOCK_W'(1);
                  running_sum_in  = SUM_W'(req_data_byte);
                  chunk_sent_in   = chunk_sent_ff + 1'b1;
                  sent_total_in   = sent_total_ff + 1'b1;
                  phase_in        = PH_BYTES;
                  tx_word         = WORD_W'(req_data_byte);
               end
            end
            PH_BYTES: begin
               if (block_sent_ff < block_length_ff) begin
                  block_sent_in  = block_sent_ff + 1'b1;
                  running_sum_in = running_sum_ff + SUM_W'(req_data_byte);
                  chunk_sent_in  = chunk_sent_ff + 1'b1;
                  sent_total_in  = sent_total_ff + 1'b1;
                  tx_word        = WORD_W'(req_data_byte);
               end else begin
                  phase_in = PH_CSUM;
                  tx_word  = WORD_W'(running_sum_ff);
               end
            end
            PH_CSUM: begin
               // A mismatched echo rewinds the block for a resend.
               if (req_rx_word == WORD_W'(running_sum_ff)) begin
                  ok_count_in = ok_count_ff + 1'b1;
                  phase_in    = (chunk_sent_ff < chunk_length_ff) ? PH_READY : PH_FLASH;
               end else begin
                  fail_count_in = fail_count_ff + 1'b1;
                  sent_total_in = sent_total_ff - TOTAL_W'(block_length_ff);
                  chunk_sent_in = chunk_sent_ff - CHUNK_W'(block_length_ff);
                  phase_in      = PH_READY;
               end
               tx_word = W_READY;
            end
            PH_FLASH: begin
               if (req_rx_word != R_FLASH) begin
                  tx_word = W_READY;
               end else if (sent_total_ff < total_bytes_ff) begin
                  phase_in = PH_CHUNK;
                  tx_word  = W_CHUNK;
               end else begin
                  phase_in = PH_DONE;
                  tx_word  = W_DONE;
               end
            end
            PH_DONE: begin
               has_result = 1'b0;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   // Protocol state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_DONE;
         sent_total_ff   <= '0;
         chunk_length_ff <= '0;
         chunk_sent_ff   <= '0;
         block_length_ff <= '0;
         block_sent_ff   <= '0;
         running_sum_ff  <= '0;
         ok_count_ff     <= '0;
         fail_count_ff   <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         sent_total_ff   <= sent_total_in;
         chunk_length_ff <= chunk_length_in;
         chunk_sent_ff   <= chunk_sent_in;
         block_length_ff <= block_length_in;
         block_sent_ff   <= block_sent_in;
         running_sum_ff  <= running_sum_in;
         ok_count_ff     <= ok_count_in;
         fail_count_ff   <= fail_count_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         out_tx_ff     <= tx_word;
         out_offset_ff <= sent_total_in[OFFSET_W-1:0];
         out_phase_ff  <= phase_in;
         out_ok_ff     <= ok_count_in;
         out_fail_ff   <= fail_count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_word       = out_tx_ff;
   assign rsp_byte_offset   = out_offset_ff;
   assign rsp_phase         = out_phase_ff;
   assign rsp_blocks_ok     = out_ok_ff;
   assign rsp_blocks_failed = out_fail_ff;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bytes_ff <= '0;
      end else if (csr_write && (paddr == CSR_TOTAL_BYTES_ADDR)) begin
         total_bytes_ff <= pwdata[TOTAL_W-1:0];
      end
   end

   assign prdata = (paddr == CSR_TOTAL_BYTES_ADDR) ? 32'(total_bytes_ff) : '0;

   // Checks
   a_block_in_range: assert property (@(posedge clock) disable iff (reset)
      block_sent_ff <= block_length_ff)
      else $error("block byte count beyond block length");

   a_chunk_in_range: assert property (@(posedge clock) disable iff (reset)
      chunk_sent_ff <= chunk_length_ff)
      else $error("chunk byte count beyond chunk length");

   a_bytes_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BYTES) |-> (block_length_ff != '0))
      else $error("byte phase entered with an empty block");

   a_csum_after_block: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CSUM) |-> (block_sent_ff == block_length_ff))
      else $error("checksum sent before the block was complete");

   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_RESTART)) |=>
         (rsp_valid && (rsp_phase == PH_SYNC1) && (rsp_tx_word == W_SYNC1)))
      else $error("restart did not produce a sync word");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lbts_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned RANDOM_ANSWERS = 400;

   // One word that the sender is expected to put on the result channel.
   typedef struct {
      logic [WORD_W-1:0]   tx_word;
      logic [OFFSET_W-1:0] byte_offset;
      phase_type           phase;
      logic [31:0]         blocks_ok;
      logic [31:0]         blocks_failed;
   } sender_word_type;

   // Tracks the sender's protocol state and the words it still owes.
   class sender_scoreboard;
      logic [TOTAL_W-1:0] total_bytes;
      phase_type          phase;
      logic [TOTAL_W-1:0] sent_total;
      logic [CHUNK_W-1:0] chunk_len;
      logic [CHUNK_W-1:0] chunk_sent;
      logic [BLOCK_W-1:0] block_len;
      logic [BLOCK_W-1:0] block_sent;
      logic [SUM_W-1:0]   running_sum;
      logic [31:0]        ok_blocks;
      logic [31:0]        bad_blocks;
      sender_word_type    owed_words[$];
      int                 errors = 0;

      function void clear_progress();
         sent_total  = '0;
         chunk_len   = '0;
         chunk_sent  = '0;
         block_len   = '0;
         block_sent  = '0;
         running_sum = '0;
         ok_blocks   = '0;
         bad_blocks  = '0;
      endfunction

      function void reset_state();
         total_bytes = '0;
         phase = PH_DONE;
         clear_progress();
         owed_words.delete();
      endfunction

      function void set_total(logic [31:0] value);
         total_bytes = value[TOTAL_W-1:0];
      endfunction

      function logic [WORD_W-1:0] take_byte(logic [BYTE_W-1:0] b);
         running_sum = running_sum + SUM_W'(b);
         block_sent++;
         chunk_sent++;
         sent_total++;
         return {24'h0, b};
      endfunction

      // Either open another chunk or close the transfer with the done marker.
      function logic [WORD_W-1:0] next_chunk_or_done();
         if (sent_total < total_bytes) begin
            phase = PH_CHUNK;
            return W_CHUNK;
         end
         phase = PH_DONE;
         return W_DONE;
      endfunction

      // Advances the protocol by one accepted item; returns 1 when a word is owed.
      function bit predict_exchange(logic act, logic [WORD_W-1:0] rx, logic [BYTE_W-1:0] db);
         sender_word_type   w;
         logic [WORD_W-1:0] tx;
         int unsigned       left;
         if (act == ACT_RESTART) begin
            clear_progress();
            phase = PH_SYNC1;
            tx = W_SYNC1;
         end else begin
            case (phase)
               PH_SYNC1: begin
                  if (rx == R_SYNC1) begin
                     phase = PH_SYNC2;
                     tx = W_SYNC2;
                  end else begin
                     tx = W_SYNC1;
                  end
               end
               PH_SYNC2: begin
                  if (rx == R_SYNC2) begin
                     tx = next_chunk_or_done();
                  end else begin
                     phase = PH_SYNC1;
                     tx = W_SYNC1;
                  end
               end
               PH_CHUNK: begin
                  left = (total_bytes > sent_total) ? total_bytes - sent_total : 0;
                  chunk_len = CHUNK_W'((left > CHUNK_BYTES) ? CHUNK_BYTES : left);
                  chunk_sent = '0;
                  phase = (chunk_len != 0) ? PH_READY : PH_FLASH;
                  tx = W_READY;
               end
               PH_READY: begin
                  if (rx == R_READY) begin
                     left = chunk_len - chunk_sent;
                     block_len = BLOCK_W'((left > BLOCK_BYTES) ? BLOCK_BYTES : left);
                     block_sent = '0;
                     running_sum = '0;
                     phase = PH_BYTES;
                     tx = take_byte(db);
                  end else begin
                     tx = W_READY;
                  end
               end
               PH_BYTES: begin
                  if (block_sent < block_len) begin
                     tx = take_byte(db);
                  end else begin
                     phase = PH_CSUM;
                     tx = {16'h0, running_sum};
                  end
               end
               PH_CSUM: begin
                  // A bad echo rewinds the block so that it goes out again.
                  if (rx == {16'h0, running_sum}) begin
                     ok_blocks++;
                     phase = (chunk_sent < chunk_len) ? PH_READY : PH_FLASH;
                  end else begin
                     bad_blocks++;
                     sent_total = sent_total - block_len;
                     chunk_sent = chunk_sent - block_len;
                     phase = PH_READY;
                  end
                  tx = W_READY;
               end
               PH_FLASH: begin
                  if (rx == R_FLASH) tx = next_chunk_or_done();
                  else tx = W_READY;
               end
               default: begin
                  return 0;
               end
            endcase
         end
         w.tx_word       = tx;
         w.byte_offset   = sent_total[OFFSET_W-1:0];
         w.phase         = phase;
         w.blocks_ok     = ok_blocks;
         w.blocks_failed = bad_blocks;
         owed_words.push_back(w);
         return 1;
      endfunction

      // Compares one delivered word with the oldest owed word.
      function void check_word(logic [WORD_W-1:0] tx, logic [OFFSET_W-1:0] off,
                               logic [2:0] ph, logic [31:0] okc, logic [31:0] badc);
         sender_word_type w;
         if (owed_words.size() == 0) begin
            $error("result item with none expected: tx_word %h", tx);
            errors++;
            return;
         end
         w = owed_words.pop_front();
         if (tx !== w.tx_word) begin
            $error("tx_word: expected %h, actual %h", w.tx_word, tx);
            errors++;
         end
         if (off !== w.byte_offset) begin
            $error("byte_offset: expected %0d, actual %0d", w.byte_offset, off);
            errors++;
         end
         if (ph !== w.phase) begin
            $error("phase: expected %0d, actual %0d", w.phase, ph);
            errors++;
         end
         if (okc !== w.blocks_ok) begin
            $error("blocks_ok: expected %0d, actual %0d", w.blocks_ok, okc);
            errors++;
         end
         if (badc !== w.blocks_failed) begin
            $error("blocks_failed: expected %0d, actual %0d", w.blocks_failed, badc);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_action = ACT_EXCHANGE;
   logic [WORD_W-1:0]   req_rx_word = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_tx_word;
   logic [OFFSET_W-1:0] rsp_byte_offset;
   logic [2:0]          rsp_phase;
   logic [31:0]         rsp_blocks_ok;
   logic [31:0]         rsp_blocks_failed;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   sender_scoreboard sb;
   bit               idle_on = 1'b1;
   int               rsp_stall = 0;
   int unsigned      answered_items = 0;
   int unsigned      cycle_count = 0;

   link_block_transfer_sender u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_rx_word       (req_rx_word),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_word       (rsp_tx_word),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_phase         (rsp_phase),
      .rsp_blocks_ok     (rsp_blocks_ok),
      .rsp_blocks_failed (rsp_blocks_failed),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("link_block_transfer_sender regression: fail");
         $finish;
      end
   end

   // Idle stretches are mostly short, now and then long.
   function automatic int pick_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
   endfunction

   // One clock: collect a delivered word, then decide the result-side stall.
   task automatic tick();
      @(posedge clock);
      if (rsp_valid === 1'b1 && rsp_ready)
         sb.check_word(rsp_tx_word, rsp_byte_offset, rsp_phase, rsp_blocks_ok,
                       rsp_blocks_failed);
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 99) < 25) rsp_stall = pick_len();
      end
   endtask

   task automatic hold_off(input int n);
      req_valid <= 1'b0;
      repeat (n) tick();
   endtask

   // Offers one item and waits until the sender takes it.
   task automatic send_item(input logic act, input logic [WORD_W-1:0] rx,
                            input logic [BYTE_W-1:0] db);
      int gap;
      bit taken;
      gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_len() : 0;
      if (gap > 0) hold_off(gap);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_rx_word   <= rx;
      req_data_byte <= db;
      taken = 1'b0;
      while (!taken) begin
         tick();
         taken = req_ready;
      end
      if (sb.predict_exchange(act, rx, db)) answered_items++;
   endtask

   task automatic exchange(input logic [WORD_W-1:0] rx, input logic [BYTE_W-1:0] db);
      send_item(ACT_EXCHANGE, rx, db);
   endtask

   // Drain every owed word, then allow for an item that produced nothing.
   task automatic settle();
      hold_off(1);
      while (sb.owed_words.size() != 0) tick();
      repeat (4) tick();
   endtask

   // Writes total_bytes and reads it back; only called after settle() has drained the result channel.
   task automatic program_total(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_TOTAL_BYTES_ADDR;
      pwdata  <= value;
      tick();
      penable <= 1'b1;
      do tick(); while (!pready);
      sb.set_total(value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tick();
      penable <= 1'b1;
      do tick(); while (!pready);
      if (prdata !== {6'h0, sb.total_bytes}) begin
         $error("total_bytes readback: expected %h, actual %h", sb.total_bytes, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      tick();
   endtask

   // What a partner on the far end of the link would answer to the last word.
   function automatic logic [WORD_W-1:0] partner_reply(input int err_pct);
      logic [WORD_W-1:0] r;
      bit good;
      good = $urandom_range(0, 99) >= err_pct;
      r = $urandom();
      case (sb.phase)
         PH_SYNC1: if (good) r = R_SYNC1;
         PH_SYNC2: if (good) r = R_SYNC2;
         PH_READY: if (good) r = R_READY;
         PH_FLASH: if (good) r = R_FLASH;
         PH_CSUM: begin
            // A bad echo is either noise or the sum with a single bit flipped.
            if (good) r = {16'h0, sb.running_sum};
            else if ($urandom_range(0, 1) == 1)
               r = {16'h0, sb.running_sum} ^ (32'h1 << $urandom_range(0, 31));
         end
         default: ;
      endcase
      return r;
   endfunction

   // One transfer from a fresh start, cut short after max_items exchanges.
   task automatic run_transfer(input logic [31:0] total, input int err_pct,
                               input int max_items, input bit noisy);
      int n;
      settle();
      program_total(total);
      send_item(ACT_RESTART, $urandom(), $urandom_range(0, 255));
      n = 0;
      while (sb.phase != PH_DONE && n < max_items) begin
         if (noisy && $urandom_range(0, 199) == 0) begin
            // Change the length in the middle of a transfer.
            settle();
            program_total($urandom_range(0, 24));
         end else if (noisy && $urandom_range(0, 199) == 0) begin
            send_item(ACT_RESTART, $urandom(), $urandom_range(0, 255));
         end else begin
            exchange(partner_reply(err_pct), $urandom_range(0, 255));
         end
         n++;
      end
      // Exchanges after the done marker are ignored by the sender.
      if (noisy && sb.phase == PH_DONE && $urandom_range(0, 2) == 0)
         exchange($urandom(), $urandom_range(0, 255));
   endtask

   initial begin
      int pick;
      logic [31:0] total;
      sb = new();
      sb.reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // An exchange straight after reset must be ignored.
      exchange(32'hFFFFFFFF, 8'hFF);

      // Handshake with bad replies, then nothing to send.
      settle();
      program_total(0);
      send_item(ACT_RESTART, 32'h0, 8'h00);
      exchange(32'hFFFFFFFF, 8'h00);
      exchange(R_SYNC1, 8'hFF);
      exchange(32'h0, 8'h00);
      exchange(R_SYNC1, 8'h00);
      exchange(R_SYNC2, 8'h00);

      // Length shrinks after the chunk marker, so the chunk is empty.
      settle();
      program_total(2);
      send_item(ACT_RESTART, 32'h0, 8'h00);
      exchange(R_SYNC1, 8'h00);
      exchange(R_SYNC2, 8'h00);
      settle();
      program_total(0);
      exchange(32'h0, 8'h00);
      exchange(R_FLASH, 8'h00);

      // A two-byte block with a bad echo, its resend and a good echo.
      settle();
      program_total(2);
      send_item(ACT_RESTART, 32'hFFFFFFFF, 8'hFF);
      exchange(R_SYNC1, 8'h00);
      exchange(R_SYNC2, 8'h00);
      exchange(32'h0, 8'h00);
      exchange(R_SYNC1, 8'h00);
      exchange(R_READY, 8'hFF);
      exchange(32'hFFFFFFFF, 8'hFF);
      exchange(32'h0, 8'h00);
      exchange({16'h0001, sb.running_sum}, 8'h00);
      exchange(R_READY, 8'h00);
      exchange(32'h0, 8'h00);
      exchange(32'h0, 8'h00);
      exchange({16'h0, sb.running_sum}, 8'h00);
      exchange(32'hFFFFFFFF, 8'h00);
      exchange(R_FLASH, 8'h00);

      // Lengths past one block and past one chunk, only the opening of the
      // transfer; the second one at full speed.
      idle_on = 1'b1;
      run_transfer(BLOCK_BYTES + $urandom_range(1, 20), 5, 40, 1'b0);
      idle_on = 1'b0;
      run_transfer(CHUNK_BYTES + $urandom_range(1, 8), 1, 40, 1'b0);

      // Lengths at and just below 2^25, only the opening of the transfer.
      idle_on = 1'b1;
      run_transfer(32'd33554432, 10, 40, 1'b0);
      run_transfer(32'h01FFFFFF, 10, 40, 1'b0);

      // Mostly short transfers with random replies and interruptions.
      answered_items = 0;
      while (answered_items < RANDOM_ANSWERS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) total = 0;
         else if (pick < 8) total = $urandom_range(1, 24);
         else total = $urandom_range(25, 300);
         run_transfer(total, $urandom_range(0, 30), 400, 1'b1);
      end

      settle();
      if (sb.errors == 0) begin
         $display("link_block_transfer_sender regression: pass");
      end else begin
         $display("link_block_transfer_sender regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lbts_pkg.sv
sv/link_block_transfer_sender.sv
test/tb.sv
